[hw/rtl/cwvo_pkg.sv]
// Shared types, constants and register codes for the curved-world vertex offset block.
package cwvo_pkg;

    // Field and port widths
    localparam int POS_WIDTH_DEF = 20;
    localparam int ORG_W         = 20;
    localparam int AX_W          = 16;
    localparam int CRV_W         = 32;
    localparam int BW_W          = 16;
    localparam int OUT_W         = 32;
    localparam int CFG_W         = 60;
    localparam int CFG_IDX_W     = 3;

    // Datapath word for all rounding multiplies
    typedef logic signed [63:0] word_t;

    // Rounding multiplier and square root latencies
    localparam int MUL_LAT    = 5;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 4;
    localparam int SQRT_LAT   = ROOT_W / SQRT_STEPS;

    // Arithmetic constants
    localparam logic [63:0] CLAMP_LIM = 64'h2000_0000_0000_0000;
    localparam word_t       ONE_Q24   = 64'sd16777216;
    localparam word_t       MILLI_Q30 = 64'sd1073742;
    localparam int          B_W       = 46;
    localparam logic [B_W-1:0] BASE_CAP = {B_W{1'b1}};

    // Register reset values
    localparam logic [3*AX_W-1:0] RIGHT_RST = 48'h0000_0000_4000;
    localparam logic [3*AX_W-1:0] FWD_RST   = 48'h0000_4000_0000;
    localparam logic [3*AX_W-1:0] UP_RST    = 48'h4000_0000_0000;
    localparam logic [BW_W-1:0]   BW_RST    = 16'h4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_ORIGIN  = 3'd1,
        REG_RIGHT   = 3'd2,
        REG_FORWARD = 3'd3,
        REG_UP      = 3'd4,
        REG_CURVE_R = 3'd5,
        REG_CURVE_F = 3'd6,
        REG_BEND    = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_VERT     = 2'd1,
        MODE_TILT     = 2'd2,
        MODE_TILT_EXP = 2'd3
    } mode_t;

endpackage

[hw/rtl/cwvo_delay.sv]
// Enabled shift line that delays a word by a fixed number of pipeline stages.
module cwvo_delay #(
    parameter int W     = 64,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [DEPTH];

    // Shift on every pipeline advance
    always_ff @(posedge clk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

[hw/rtl/cwvo_mulsh.sv]
// Pipelined signed multiply, round half away from zero, shift and clamp to +-2^61.
module cwvo_mulsh import cwvo_pkg::*; #(
    parameter int SH = 14
) (
    input  logic  clk,
    input  logic  en,
    input  word_t a,
    input  word_t b,
    input  logic  flip,
    output word_t q,
    output logic  sat
);

    localparam logic [127:0] RND = 128'd1 << (SH - 1);

    logic [63:0]  ua_reg, ub_reg;
    logic         neg1_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic         neg2_reg;
    logic [127:0] prod_reg;
    logic         neg3_reg;
    logic [61:0]  mag_reg;
    logic         over_reg, neg4_reg;
    word_t        q_reg;
    logic         sat_reg;

    logic [127:0] rnd_full, shf;
    logic         over_c;
    logic [63:0]  mag5;

    // Rounding, shift and range check of the full product
    always_comb begin
        rnd_full = prod_reg + RND;
        shf      = rnd_full >> SH;
        over_c   = (shf[127:62] != '0) || (shf[61] && (shf[60:0] != '0));
        mag5     = over_reg ? CLAMP_LIM : {2'b00, mag_reg};
    end

    always_ff @(posedge clk) begin
        if (en) begin
            // stage 1: sign and magnitude
            ua_reg   <= a[63] ? 64'(-a) : 64'(a);
            ub_reg   <= b[63] ? 64'(-b) : 64'(b);
            neg1_reg <= a[63] ^ b[63] ^ flip;
            // stage 2: four 32x32 partial products
            p00_reg  <= ua_reg[31:0]  * ub_reg[31:0];
            p01_reg  <= ua_reg[31:0]  * ub_reg[63:32];
            p10_reg  <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg  <= ua_reg[63:32] * ub_reg[63:32];
            neg2_reg <= neg1_reg;
            // stage 3: full product
            prod_reg <= {64'b0, p00_reg} + {32'b0, p01_reg, 32'b0}
                      + {32'b0, p10_reg, 32'b0} + {p11_reg, 64'b0};
            neg3_reg <= neg2_reg;
            // stage 4: rounded and shifted magnitude
            mag_reg  <= shf[61:0];
            over_reg <= over_c;
            neg4_reg <= neg3_reg;
            // stage 5: clamp and restore sign
            q_reg    <= neg4_reg ? word_t'(-mag5) : word_t'(mag5);
            sat_reg  <= over_reg;
        end
    end

    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

[hw/rtl/cwvo_isqrt.sv]
// Pipelined floor square root of a 64-bit value, a few result bits per stage.
module cwvo_isqrt import cwvo_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [63:0]       x,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 1;
    localparam int RW_W  = ROOT_W + 3;

    logic [63:0]       x_reg    [SQRT_LAT];
    logic [REM_W-1:0]  rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [SQRT_LAT];

    genvar s;
    for (s = 0; s < SQRT_LAT; s++) begin : g_stage
        logic [63:0]       x_src, x_next;
        logic [REM_W-1:0]  rem_src, rem_next;
        logic [ROOT_W-1:0] root_src, root_next;

        if (s == 0) begin : g_first
            assign x_src    = x;
            assign rem_src  = '0;
            assign root_src = '0;
        end else begin : g_rest
            assign x_src    = x_reg[s-1];
            assign rem_src  = rem_reg[s-1];
            assign root_src = root_reg[s-1];
        end

        // Restoring digit steps, one bit pair each
        always_comb begin
            logic [RW_W-1:0] rw, tr;
            x_next    = x_src;
            rem_next  = rem_src;
            root_next = root_src;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                rw = {rem_next, x_next[63:62]};
                tr = {1'b0, root_next, 2'b01};
                if (rw >= tr) begin
                    rem_next  = REM_W'(rw - tr);
                    root_next = {root_next[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rw[REM_W-1:0];
                    root_next = {root_next[ROOT_W-2:0], 1'b0};
                end
                x_next = x_next << 2;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                x_reg[s]    <= x_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

[hw/rtl/curved_world_vertex_offset.sv]
// Curved-world vertex offset: top level with configuration registers and the main pipeline.
//
// Each item is one world position; the block returns its curved-world displacement in Q24.8
// with a saturation flag. It accepts one item per clock while the result register can take
// an item. The pipeline depth is set by the height-factor path: three stages for the
// origin offset and axis projections, a rounding multiply for the linear height term, one
// stage for the power base, the eight-stage square root, three more rounding multiplies in
// series (power, height scaling, axis rebuild; each built from 32x32 partial products) and
// the result register. When the result register is held by the consumer, the whole pipeline
// holds; nothing is lost or repeated. Configuration registers are written through the plain
// write port; a write reaches items already in flight as well, so the user must keep writes
// to an empty pipeline for them to take effect for the items accepted after the write.
module curved_world_vertex_offset import cwvo_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [POS_WIDTH-1:0] s_pos_x,
    input  logic signed [POS_WIDTH-1:0] s_pos_y,
    input  logic signed [POS_WIDTH-1:0] s_pos_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_W-1:0]     m_offset_x,
    output logic signed [OUT_W-1:0]     m_offset_y,
    output logic signed [OUT_W-1:0]     m_offset_z,
    output logic                        m_saturated,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata
);

    localparam int D_W = ((POS_WIDTH > ORG_W) ? POS_WIDTH : ORG_W) + 1;
    localparam int M_W = D_W + AX_W;
    localparam int P_W = M_W + 2;

    // Stage numbers: the stage whose register holds each value
    localparam int ST_P    = 3;
    localparam int ST_SQ   = ST_P + MUL_LAT;
    localparam int ST_B    = ST_SQ + 1;
    localparam int ST_BX   = ST_SQ + MUL_LAT;
    localparam int ST_SUM  = ST_BX + 1;
    localparam int ST_Z1   = ST_SUM + MUL_LAT;
    localparam int ST_ROOT = ST_B + SQRT_LAT;
    localparam int ST_H    = ST_ROOT + MUL_LAT;
    localparam int ST_ZB   = ST_H + MUL_LAT;
    localparam int ST_RB   = ST_ZB + MUL_LAT;

    // Configuration registers
    mode_t                 mode_reg;
    logic [3*ORG_W-1:0]    origin_reg;
    logic [3*AX_W-1:0]     right_reg, fwd_reg, up_reg;
    logic [CRV_W-1:0]      crv_r_reg, crv_f_reg;
    logic [BW_W-1:0]       bw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NONE;
            origin_reg <= '0;
            right_reg  <= RIGHT_RST;
            fwd_reg    <= FWD_RST;
            up_reg     <= UP_RST;
            crv_r_reg  <= '0;
            crv_f_reg  <= '0;
            bw_reg     <= BW_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:    mode_reg   <= mode_t'(cfg_wdata[1:0]);
                REG_ORIGIN:  origin_reg <= cfg_wdata[3*ORG_W-1:0];
                REG_RIGHT:   right_reg  <= cfg_wdata[3*AX_W-1:0];
                REG_FORWARD: fwd_reg    <= cfg_wdata[3*AX_W-1:0];
                REG_UP:      up_reg     <= cfg_wdata[3*AX_W-1:0];
                REG_CURVE_R: crv_r_reg  <= cfg_wdata[CRV_W-1:0];
                REG_CURVE_F: crv_f_reg  <= cfg_wdata[CRV_W-1:0];
                REG_BEND:    bw_reg     <= cfg_wdata[BW_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpacked register fields
    logic signed [ORG_W-1:0] org   [3];
    logic signed [AX_W-1:0]  ax_r  [3];
    logic signed [AX_W-1:0]  ax_f  [3];
    logic signed [AX_W-1:0]  ax_u  [3];
    logic signed [AX_W-1:0]  ax_re [3];
    logic signed [AX_W-1:0]  ax_fe [3];

    // Vertical-only mode drops the z terms of the horizontal projections
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            org[i]   = origin_reg[i*ORG_W +: ORG_W];
            ax_r[i]  = right_reg[i*AX_W +: AX_W];
            ax_f[i]  = fwd_reg[i*AX_W +: AX_W];
            ax_u[i]  = up_reg[i*AX_W +: AX_W];
            ax_re[i] = ax_r[i];
            ax_fe[i] = ax_f[i];
        end
        if (mode_reg == MODE_VERT) begin
            ax_re[2] = '0;
            ax_fe[2] = '0;
        end
    end

    word_t cr64, cf64, bw64;
    assign cr64 = word_t'($signed(crv_r_reg));
    assign cf64 = word_t'($signed(crv_f_reg));
    assign bw64 = word_t'({{(64-BW_W){1'b0}}, bw_reg});

    // Flow control: the whole pipeline advances when the result register can take an item
    logic             adv;
    logic [ST_RB:0]   vld_reg;
    logic             m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[ST_RB-1:0], s_valid};
            m_valid_reg <= vld_reg[ST_RB];
        end
    end

    // Stages 0 to 3: capture, offset from origin, axis products, projections
    logic signed [POS_WIDTH-1:0] pos_reg [3];
    logic signed [D_W-1:0]       d_reg   [3];
    logic signed [M_W-1:0]       mr_reg  [3];
    logic signed [M_W-1:0]       mf_reg  [3];
    logic signed [M_W-1:0]       mu_reg  [3];
    logic signed [P_W-1:0]       px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            for (int i = 0; i < 3; i++) begin
                d_reg[i]  <= D_W'(pos_reg[i]) - D_W'(org[i]);
                mr_reg[i] <= d_reg[i] * ax_re[i];
                mf_reg[i] <= d_reg[i] * ax_fe[i];
                mu_reg[i] <= d_reg[i] * ax_u[i];
            end
            px_reg <= P_W'(mr_reg[0]) + P_W'(mr_reg[1]) + P_W'(mr_reg[2]);
            py_reg <= P_W'(mf_reg[0]) + P_W'(mf_reg[1]) + P_W'(mf_reg[2]);
            pz_reg <= P_W'(mu_reg[0]) + P_W'(mu_reg[1]) + P_W'(mu_reg[2]);
        end
    end

    // Squares of the horizontal projections and the linear height term
    word_t sq_x, sq_y, lin;
    logic  sq_x_sat, sq_y_sat, lin_sat;

    cwvo_mulsh #(.SH(20)) u_sq_x (
        .clk(aclk), .en(adv), .a(word_t'(px_reg)), .b(word_t'(px_reg)), .flip(1'b0),
        .q(sq_x), .sat(sq_x_sat)
    );
    cwvo_mulsh #(.SH(20)) u_sq_y (
        .clk(aclk), .en(adv), .a(word_t'(py_reg)), .b(word_t'(py_reg)), .flip(1'b0),
        .q(sq_y), .sat(sq_y_sat)
    );
    cwvo_mulsh #(.SH(20)) u_lin (
        .clk(aclk), .en(adv), .a(word_t'(pz_reg)), .b(MILLI_Q30), .flip(1'b0),
        .q(lin), .sat(lin_sat)
    );

    // Projection signs follow the squares; tilt is negated for a non-negative projection
    logic [1:0] pneg_d;
    cwvo_delay #(.W(2), .DEPTH(MUL_LAT)) u_pneg_dly (
        .clk(aclk), .en(adv), .d({px_reg[P_W-1], py_reg[P_W-1]}), .q(pneg_d)
    );

    // Quadratic bends and tilts
    word_t bx, by, tx, ty;
    logic  bx_sat, by_sat, tx_sat, ty_sat;

    cwvo_mulsh #(.SH(40)) u_bx (
        .clk(aclk), .en(adv), .a(sq_x), .b(cr64), .flip(1'b0), .q(bx), .sat(bx_sat)
    );
    cwvo_mulsh #(.SH(40)) u_by (
        .clk(aclk), .en(adv), .a(sq_y), .b(cf64), .flip(1'b0), .q(by), .sat(by_sat)
    );
    cwvo_mulsh #(.SH(41)) u_tx (
        .clk(aclk), .en(adv), .a(sq_x), .b(cr64), .flip(!pneg_d[1]), .q(tx), .sat(tx_sat)
    );
    cwvo_mulsh #(.SH(41)) u_ty (
        .clk(aclk), .en(adv), .a(sq_y), .b(cf64), .flip(!pneg_d[0]), .q(ty), .sat(ty_sat)
    );

    word_t sumb_reg, tx_reg, ty_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sumb_reg <= bx + by;
            tx_reg   <= tx;
            ty_reg   <= ty;
        end
    end

    // Bend weight
    word_t z1, xw, yw;
    logic  z1_sat, xw_sat, yw_sat;

    cwvo_mulsh #(.SH(14)) u_z1 (
        .clk(aclk), .en(adv), .a(sumb_reg), .b(bw64), .flip(1'b0), .q(z1), .sat(z1_sat)
    );
    cwvo_mulsh #(.SH(14)) u_xw (
        .clk(aclk), .en(adv), .a(tx_reg), .b(bw64), .flip(1'b0), .q(xw), .sat(xw_sat)
    );
    cwvo_mulsh #(.SH(14)) u_yw (
        .clk(aclk), .en(adv), .a(ty_reg), .b(bw64), .flip(1'b0), .q(yw), .sat(yw_sat)
    );

    // Height factor base: 1 + lin, clamped below at 1 and capped for the power form
    logic [B_W-1:0] b_reg;
    logic           cap_reg;
    word_t          h2_reg;
    word_t          lin_pos, bsum;
    logic           cap_c;

    always_comb begin
        lin_pos = lin[63] ? '0 : lin;
        bsum    = ONE_Q24 + lin_pos;
        cap_c   = bsum > word_t'({{(64-B_W){1'b0}}, BASE_CAP});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_reg   <= cap_c ? BASE_CAP : bsum[B_W-1:0];
            cap_reg <= cap_c && (mode_reg == MODE_TILT_EXP);
            h2_reg  <= ONE_Q24 + lin;
        end
    end

    // h = b * sqrt(b), with b in Q.24
    logic [ROOT_W-1:0] root;
    logic [B_W-1:0]    b_d;
    word_t             hm3, h2_d, h_sel;
    logic              hm3_sat;

    cwvo_isqrt u_isqrt (
        .clk(aclk), .en(adv), .x({{(48-B_W){1'b0}}, b_reg, 16'b0}), .root(root)
    );
    cwvo_delay #(.W(B_W), .DEPTH(SQRT_LAT)) u_b_dly (
        .clk(aclk), .en(adv), .d(b_reg), .q(b_d)
    );
    cwvo_mulsh #(.SH(20)) u_hm3 (
        .clk(aclk), .en(adv),
        .a(word_t'({{(64-B_W){1'b0}}, b_d})), .b(word_t'({{(64-ROOT_W){1'b0}}, root})),
        .flip(1'b0), .q(hm3), .sat(hm3_sat)
    );
    cwvo_delay #(.W(64), .DEPTH(ST_H - ST_B)) u_h2_dly (
        .clk(aclk), .en(adv), .d(h2_reg), .q(h2_d)
    );

    assign h_sel = (mode_reg == MODE_TILT_EXP) ? hm3 : h2_d;

    // Align the weighted bends with the height factor
    word_t z1_d, xw_d, yw_d, z1_m1;
    cwvo_delay #(.W(192), .DEPTH(ST_H - ST_Z1)) u_w_dly (
        .clk(aclk), .en(adv), .d({z1, xw, yw}), .q({z1_d, xw_d, yw_d})
    );
    cwvo_delay #(.W(64), .DEPTH(ST_RB - ST_H)) u_z1_dly (
        .clk(aclk), .en(adv), .d(z1_d), .q(z1_m1)
    );

    // Height scaling
    word_t zb, xb, yb;
    logic  zb_sat, xb_sat, yb_sat;

    cwvo_mulsh #(.SH(24)) u_zb (
        .clk(aclk), .en(adv), .a(z1_d), .b(h_sel), .flip(1'b0), .q(zb), .sat(zb_sat)
    );
    cwvo_mulsh #(.SH(24)) u_xb (
        .clk(aclk), .en(adv), .a(xw_d), .b(h_sel), .flip(1'b0), .q(xb), .sat(xb_sat)
    );
    cwvo_mulsh #(.SH(24)) u_yb (
        .clk(aclk), .en(adv), .a(yw_d), .b(h_sel), .flip(1'b0), .q(yb), .sat(yb_sat)
    );

    // Rebuild world components from the camera axes
    word_t      rbx [3];
    word_t      rby [3];
    word_t      rbz [3];
    logic [2:0] rbx_sat, rby_sat, rbz_sat;

    genvar g;
    for (g = 0; g < 3; g++) begin : g_rb
        cwvo_mulsh #(.SH(14)) u_rx (
            .clk(aclk), .en(adv), .a(xb), .b(word_t'(ax_r[g])), .flip(1'b0),
            .q(rbx[g]), .sat(rbx_sat[g])
        );
        cwvo_mulsh #(.SH(14)) u_ry (
            .clk(aclk), .en(adv), .a(yb), .b(word_t'(ax_f[g])), .flip(1'b0),
            .q(rby[g]), .sat(rby_sat[g])
        );
        cwvo_mulsh #(.SH(14)) u_rz (
            .clk(aclk), .en(adv), .a(zb), .b(word_t'(ax_u[g])), .flip(1'b0),
            .q(rbz[g]), .sat(rbz_sat[g])
        );
    end

    // Saturation flags, gathered stage by stage; ext flags count in the tilt modes only
    logic [ST_RB:0] flgc, flge;
    logic [ST_RB:0] satc_reg, sate_reg;

    always_comb begin
        flgc         = '0;
        flge         = '0;
        flgc[ST_SQ]  = flgc[ST_SQ] | sq_x_sat | sq_y_sat;
        flgc[ST_BX]  = flgc[ST_BX] | bx_sat | by_sat;
        flgc[ST_Z1]  = flgc[ST_Z1] | z1_sat;
        flge[ST_SQ]  = flge[ST_SQ] | lin_sat;
        flge[ST_B]   = flge[ST_B] | cap_reg;
        flge[ST_BX]  = flge[ST_BX] | tx_sat | ty_sat;
        flge[ST_Z1]  = flge[ST_Z1] | xw_sat | yw_sat;
        flge[ST_H]   = flge[ST_H] | (hm3_sat && (mode_reg == MODE_TILT_EXP));
        flge[ST_ZB]  = flge[ST_ZB] | zb_sat | xb_sat | yb_sat;
        flge[ST_RB]  = flge[ST_RB] | (|rbx_sat) | (|rby_sat) | (|rbz_sat);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            satc_reg <= {satc_reg[ST_RB-1:0] | flgc[ST_RB-1:0], 1'b0};
            sate_reg <= {sate_reg[ST_RB-1:0] | flge[ST_RB-1:0], 1'b0};
        end
    end

    // Final sum, mode select and 32-bit clamp
    word_t                 fin   [3];
    logic signed [OUT_W-1:0] clp [3];
    logic [2:0]            ovf;
    logic                  sat_fin;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fin[i] = '0;
        end
        case (mode_reg)
            MODE_NONE: ;
            MODE_VERT: fin[2] = z1_m1;
            default: begin
                for (int i = 0; i < 3; i++) begin
                    fin[i] = rbx[i] + rby[i] + rbz[i];
                end
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            ovf[i] = !((&fin[i][63:OUT_W-1]) || !(|fin[i][63:OUT_W-1]));
            if (ovf[i]) begin
                clp[i] = fin[i][63] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                clp[i] = fin[i][OUT_W-1:0];
            end
        end
        sat_fin = (mode_reg != MODE_NONE)
                  && ((satc_reg[ST_RB] | flgc[ST_RB])
                      || (((mode_reg == MODE_TILT) || (mode_reg == MODE_TILT_EXP))
                          && (sate_reg[ST_RB] | flge[ST_RB]))
                      || (|ovf));
    end

    // Result register
    logic signed [OUT_W-1:0] ox_reg, oy_reg, oz_reg;
    logic                    osat_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg   <= clp[0];
            oy_reg   <= clp[1];
            oz_reg   <= clp[2];
            osat_reg <= sat_fin;
        end
    end

    assign m_offset_x  = ox_reg;
    assign m_offset_y  = oy_reg;
    assign m_offset_z  = oz_reg;
    assign m_saturated = osat_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_mode_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (mode_reg == MODE_NONE)) |->
        (m_offset_x == 0) && (m_offset_y == 0) && (m_offset_z == 0) && !m_saturated)
        else $error("nonzero result with bending off");

    a_mode_vert: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (mode_reg == MODE_VERT)) |-> (m_offset_x == 0) && (m_offset_y == 0))
        else $error("horizontal offset in vertical-only mode");
`endif

endmodule

[tb/tb_curved_world_vertex_offset.sv]
// Self-checking testbench for the curved-world vertex offset block.
module tb_curved_world_vertex_offset;
    import cwvo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = 20;
    localparam int LATENCY = 33;

    typedef struct packed {
        logic signed [PW-1:0] x, y, z;
    } position_t;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz;
        logic               sat;
    } displacement_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [PW-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_offset_x, m_offset_y, m_offset_z;
    logic m_saturated;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    curved_world_vertex_offset #(.POS_WIDTH(PW)) uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the configuration
    logic [1:0]  sh_mode;
    logic [59:0] sh_origin;
    logic [47:0] sh_right, sh_fwd, sh_up;
    logic [31:0] sh_cr, sh_cf;
    logic [15:0] sh_bw;

    position_t     pending_positions[$];
    displacement_t expected_offsets[$];
    int  error_count = 0;
    int  result_count = 0;
    bit  quiet_tail = 0;
    bit  hold_off = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at result %0d: got %h expected %h", what, result_count, got,
                 want);
        error_count++;
    endtask

    // round(a*b/2^sh), ties away from zero, magnitude clamped to 2^61
    function automatic longint scaled_mul(input longint a, input longint b, input int sh,
                                          ref bit sat);
        logic [127:0] ua, ub, pr, q;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 128'(-a) : 128'(a);
        ub = b < 0 ? 128'(-b) : 128'(b);
        ua = ua & 128'hFFFF_FFFF_FFFF_FFFF;
        ub = ub & 128'hFFFF_FFFF_FFFF_FFFF;
        pr = ua * ub;
        if (sh > 0) pr = pr + (128'd1 << (sh - 1));
        q = pr >> sh;
        if (q > (128'd1 << 61)) begin
            q = 128'd1 << 61;
            sat = 1;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint floor_root(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint axis_field(input logic [47:0] r, input int i);
        return longint'($signed(r[i*16 +: 16]));
    endfunction

    function automatic displacement_t bend_offset(input position_t p);
        displacement_t o;
        bit sat;
        longint d[3], ra[3], fa[3], ua[3], res[3];
        longint px, py, pz, lin, h, b, bx, by, zb, xb, yb, cr, cf, bw, v;
        sat = 0;
        cr = longint'($signed(sh_cr));
        cf = longint'($signed(sh_cf));
        bw = longint'(sh_bw);
        d[0] = longint'(p.x) - longint'($signed(sh_origin[19:0]));
        d[1] = longint'(p.y) - longint'($signed(sh_origin[39:20]));
        d[2] = longint'(p.z) - longint'($signed(sh_origin[59:40]));
        for (int i = 0; i < 3; i++) begin
            ra[i] = axis_field(sh_right, i);
            fa[i] = axis_field(sh_fwd, i);
            ua[i] = axis_field(sh_up, i);
            res[i] = 0;
        end
        if (sh_mode == MODE_VERT) begin
            px = d[0]*ra[0] + d[1]*ra[1];
            py = d[0]*fa[0] + d[1]*fa[1];
            bx = scaled_mul(scaled_mul(px, px, 20, sat), cr, 40, sat);
            by = scaled_mul(scaled_mul(py, py, 20, sat), cf, 40, sat);
            res[2] = scaled_mul(bx + by, bw, 14, sat);
        end else if (sh_mode == MODE_TILT || sh_mode == MODE_TILT_EXP) begin
            px = d[0]*ra[0] + d[1]*ra[1] + d[2]*ra[2];
            py = d[0]*fa[0] + d[1]*fa[1] + d[2]*fa[2];
            pz = d[0]*ua[0] + d[1]*ua[1] + d[2]*ua[2];
            lin = scaled_mul(pz, 1073742, 20, sat);
            if (sh_mode == MODE_TILT) begin
                h = (64'sd1 << 24) + lin;
            end else begin
                b = (64'sd1 << 24) + (lin < 0 ? 0 : lin);
                if (b > (64'sd1 << 46) - 1) begin
                    b = (64'sd1 << 46) - 1;
                    sat = 1;
                end
                h = scaled_mul(b, floor_root(b << 16), 20, sat);
            end
            bx = scaled_mul(scaled_mul(px, px, 20, sat), cr, 40, sat);
            by = scaled_mul(scaled_mul(py, py, 20, sat), cf, 40, sat);
            zb = scaled_mul(scaled_mul(bx + by, bw, 14, sat), h, 24, sat);
            xb = -scaled_mul(scaled_mul(px, px < 0 ? -px : px, 20, sat), cr, 41, sat);
            xb = scaled_mul(scaled_mul(xb, bw, 14, sat), h, 24, sat);
            yb = -scaled_mul(scaled_mul(py, py < 0 ? -py : py, 20, sat), cf, 41, sat);
            yb = scaled_mul(scaled_mul(yb, bw, 14, sat), h, 24, sat);
            for (int i = 0; i < 3; i++)
                res[i] = scaled_mul(xb, ra[i], 14, sat) + scaled_mul(yb, fa[i], 14, sat)
                       + scaled_mul(zb, ua[i], 14, sat);
        end
        for (int i = 0; i < 3; i++) begin
            v = res[i];
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647;
                sat = 1;
            end else if (v < -64'sd2147483648) begin
                v = -64'sd2147483648;
                sat = 1;
            end
            res[i] = v;
        end
        o.ox = res[0][31:0];
        o.oy = res[1][31:0];
        o.oz = res[2][31:0];
        o.sat = sat;
        return o;
    endfunction

    // Register write while idle, mirrored into the shadow copy
    task automatic write_reg(input cfg_reg_t idx, input logic [59:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:    sh_mode = val[1:0];
            REG_ORIGIN:  sh_origin = val;
            REG_RIGHT:   sh_right = val[47:0];
            REG_FORWARD: sh_fwd = val[47:0];
            REG_UP:      sh_up = val[47:0];
            REG_CURVE_R: sh_cr = val[31:0];
            REG_CURVE_F: sh_cf = val[31:0];
            REG_BEND:    sh_bw = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_positions.size() != 0 || s_valid || expected_offsets.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_axis_comp(input int kind);
        case (kind)
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_config(input int style);
        logic [59:0] org;
        logic [47:0] ax;
        int cs;
        write_reg(REG_MODE, 60'($urandom_range(0, 3)));
        org = {20'($urandom_range(0, 4000) - 2000), 20'($urandom_range(0, 4000) - 2000),
               20'($urandom_range(0, 4000) - 2000)};
        if (style == 1) org = 60'({$urandom, $urandom});
        write_reg(REG_ORIGIN, org);
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++)
                ax[i*16 +: 16] = rand_axis_comp(style == 1 ? 5 : $urandom_range(0, 7));
            write_reg(a == 0 ? REG_RIGHT : (a == 1 ? REG_FORWARD : REG_UP), 60'(ax));
        end
        cs = $urandom_range(0, 3);
        write_reg(REG_CURVE_R, cs == 0 ? 60'($urandom) :
                  60'({{12{1'b0}}, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19))}));
        write_reg(REG_CURVE_F, cs == 1 ? 60'($urandom) :
                  60'(32'($signed($urandom_range(0, 1 << 20)) - (1 << 19))));
        write_reg(REG_BEND, 60'($urandom_range(0, 65535)));
    endtask

    function automatic position_t rand_position(input bit wide);
        position_t p;
        if (wide) begin
            p = position_t'({$urandom, $urandom});
        end else begin
            p.x = PW'($urandom_range(0, 8000) - 4000);
            p.y = PW'($urandom_range(0, 8000) - 4000);
            p.z = PW'($urandom_range(0, 8000) - 4000);
        end
        return p;
    endfunction

    int send_gap = 0;

    bit accepted_last;
    always @(posedge aclk) begin
        accepted_last <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_offsets.push_back(bend_offset(position_t'({s_pos_x, s_pos_y, s_pos_z})));
    end

    // Sender: falls to a new item after each acceptance, idles in bursts
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || accepted_last) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_positions.size() != 0) begin
                    position_t p;
                    p = pending_positions.pop_front();
                    s_pos_x <= p.x;
                    s_pos_y <= p.y;
                    s_pos_z <= p.z;
                    s_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off
    int recv_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 9) == 0)
                recv_gap <= $urandom_range(1, 14);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_offsets.size() == 0) begin
                $display("unexpected result %0d", result_count);
                error_count++;
            end else begin
                displacement_t e;
                e = expected_offsets.pop_front();
                if (m_offset_x !== e.ox) report_mismatch("offset_x", m_offset_x, e.ox);
                if (m_offset_y !== e.oy) report_mismatch("offset_y", m_offset_y, e.oy);
                if (m_offset_z !== e.oz) report_mismatch("offset_z", m_offset_z, e.oz);
                if (m_saturated !== e.sat) report_mismatch("saturated", m_saturated, e.sat);
            end
            result_count++;
        end
    end

    initial begin
        #4_000_000;
        $display("tb_curved_world_vertex_offset: FAIL");
        $finish;
    end

    initial begin
        position_t p;
        sh_mode = MODE_NONE; sh_origin = '0; sh_right = RIGHT_RST; sh_fwd = FWD_RST;
        sh_up = UP_RST; sh_cr = '0; sh_cf = '0; sh_bw = BW_RST;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, then each mode at the field extremes
        pending_positions.push_back(position_t'({20'sh7FFFF, 20'sh80000, 20'sh00000}));
        wait_drained();
        write_reg(REG_CURVE_R, 60'h0_0000_7FFF_FFFF);
        write_reg(REG_CURVE_F, 60'h0_0000_8000_0000);
        write_reg(REG_BEND, 60'hFFFF);
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_MODE, 60'(m));
            pending_positions.push_back(position_t'({20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF}));
            pending_positions.push_back(position_t'({20'sh80000, 20'sh80000, 20'sh80000}));
            pending_positions.push_back(position_t'({20'sh00000, 20'sh00000, 20'sh00000}));
            pending_positions.push_back(position_t'({20'sh00400, 20'shFFC00, 20'shFF000}));
            pending_positions.push_back(position_t'({20'sh7FFFF, 20'sh80000, 20'sh7FFFF}));
            wait_drained();
        end
        // Small curves, origin and axes at extremes, negative height in mode 2
        write_reg(REG_ORIGIN, 60'hF_FFFF_8000_07FFF);
        write_reg(REG_RIGHT, 60'h8000_7FFF_C000);
        write_reg(REG_FORWARD, 60'h7FFF_8000_4000);
        write_reg(REG_UP, 60'h4000_0000_8000);
        write_reg(REG_CURVE_R, 60'h0000_1000);
        write_reg(REG_CURVE_F, 60'hFFFF_F000);
        write_reg(REG_BEND, 60'h0000);
        write_reg(REG_MODE, 60'(MODE_TILT));
        pending_positions.push_back(position_t'({20'sh00100, 20'sh00100, 20'sh80000}));
        wait_drained();
        write_reg(REG_BEND, 60'h4000);
        pending_positions.push_back(position_t'({20'sh00100, 20'sh00100, 20'sh80000}));
        wait_drained();

        // Random phases; one has a long receiver hold-off
        for (int ph = 0; ph < 11; ph++) begin
            random_config(ph % 4 == 0 ? 1 : 0);
            if (ph == 10) quiet_tail = 1;
            for (int k = 0; k < 100; k++) begin
                p = rand_position($urandom_range(0, 3) == 0);
                pending_positions.push_back(p);
            end
            if (ph == 3) begin
                @(negedge aclk);
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("tb_curved_world_vertex_offset: PASS");
        else
            $display("tb_curved_world_vertex_offset: FAIL");
        $finish;
    end
endmodule
